// ===== hdl/lidar_frame_parser_defines.svh =====
// Assertion macros shared by the range-sensor frame parser modules.
`ifndef LIDAR_FRAME_PARSER_DEFINES_SVH
`define LIDAR_FRAME_PARSER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk_i and disabled while in reset.
`define LFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while in reset.
`define LFP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LFP_ASSERT_NOW(lbl, ante, cons, msg)
`define LFP_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== hdl/lfp_pkg.sv =====
// Constants and types shared by the range-sensor frame parser.
package lfp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned PosW  = 5;
  localparam int unsigned DistW = 20;

  // Frame marker bytes.
  localparam logic [ByteW-1:0] Hdr0    = 8'hAE;
  localparam logic [ByteW-1:0] Hdr1    = 8'hA7;
  localparam logic [ByteW-1:0] LenAck  = 8'h04;
  localparam logic [ByteW-1:0] LenMeas = 8'h17;
  localparam logic [ByteW-1:0] End0    = 8'hBC;
  localparam logic [ByteW-1:0] End1    = 8'hBE;

  // Byte positions within a frame.
  localparam logic [PosW-1:0] PosHdr0      = 5'd0;
  localparam logic [PosW-1:0] PosHdr1      = 5'd1;
  localparam logic [PosW-1:0] PosLen       = 5'd2;
  localparam logic [PosW-1:0] PosFirstSum  = 5'd3;
  localparam logic [PosW-1:0] PosHi        = 5'd7;
  localparam logic [PosW-1:0] PosLo        = 5'd8;
  localparam logic [PosW-1:0] PosLastSum   = 5'd23;
  localparam logic [PosW-1:0] PosCsum      = 5'd24;
  localparam logic [PosW-1:0] PosEnd0      = 5'd25;
  localparam logic [PosW-1:0] PosEnd1      = 5'd26;

  // Frame kinds as reported on tuser.
  localparam logic KindMeas = 1'b0;
  localparam logic KindAck  = 1'b1;

  // Distance reported for an acknowledge frame and the floor for a measurement.
  localparam logic [DistW-1:0] DistMin = 20'd1;

  // Result of one parser step.
  typedef struct packed {
    logic             valid;
    logic [DistW-1:0] distance;
    logic             frame_kind;
  } lfp_result_t;

endpackage

// ===== hdl/lfp_core.sv =====
// Frame position tracker, checksum and distance calculation for one byte per step.
`include "lidar_frame_parser_defines.svh"

module lfp_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [lfp_pkg::ByteW-1:0]  byte_i,
  output lfp_pkg::lfp_result_t       res_o
);
  import lfp_pkg::*;

  logic [PosW-1:0]  pos_q, pos_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic [ByteW-1:0] csum_q, csum_d;
  logic [ByteW-1:0] hi_q, hi_d;
  logic [ByteW-1:0] lo_q, lo_d;
  logic [15:0]      raw_dist;
  logic [DistW-1:0] scaled_dist;
  lfp_result_t      res;

  // Times ten as two shifted adds.
  assign raw_dist    = {hi_q, lo_q};
  assign scaled_dist = {1'b0, raw_dist, 3'b000} + {3'b000, raw_dist, 1'b0};

  // Next state and result for the byte at the current position.
  always_comb begin
    pos_d  = pos_q;
    sum_d  = sum_q;
    csum_d = csum_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    res    = '{valid: 1'b0, distance: DistMin, frame_kind: KindMeas};
    priority if (pos_q == PosHdr0) begin
      pos_d = (byte_i == Hdr0) ? PosHdr1 : PosHdr0;
    end else if (pos_q == PosHdr1) begin
      pos_d = (byte_i == Hdr1) ? PosLen : PosHdr0;
    end else if (pos_q == PosLen) begin
      pos_d = PosHdr0;
      if (byte_i == LenAck) begin
        res = '{valid: 1'b1, distance: DistMin, frame_kind: KindAck};
      end else if (byte_i == LenMeas) begin
        sum_d = byte_i;
        pos_d = PosFirstSum;
      end
    end else if (pos_q <= PosLastSum) begin
      sum_d = sum_q + byte_i;
      if (pos_q == PosHi) begin
        hi_d = byte_i;
      end
      if (pos_q == PosLo) begin
        lo_d = byte_i;
      end
      pos_d = pos_q + 5'd1;
    end else if (pos_q == PosCsum) begin
      csum_d = byte_i;
      pos_d  = PosEnd0;
    end else if (pos_q == PosEnd0) begin
      pos_d = (byte_i == End0) ? PosEnd1 : PosHdr0;
    end else if (pos_q == PosEnd1) begin
      pos_d = PosHdr0;
      if (byte_i == End1 && csum_q == sum_q) begin
        res.valid    = 1'b1;
        res.distance = (scaled_dist == '0) ? DistMin : scaled_dist;
      end
    end else begin
      pos_d = PosHdr0;
    end
  end

  assign res_o = '{valid: res.valid & step_i, distance: res.distance,
                   frame_kind: res.frame_kind};

  // Frame state advances only on a step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      sum_q  <= '0;
      csum_q <= '0;
      hi_q   <= '0;
      lo_q   <= '0;
    end else if (step_i) begin
      pos_q  <= pos_d;
      sum_q  <= sum_d;
      csum_q <= csum_d;
      hi_q   <= hi_d;
      lo_q   <= lo_d;
    end
  end

  `LFP_ASSERT_NOW(a_pos_range, 1'b1, pos_q <= PosEnd1, "Frame position beyond the last byte.")
  `LFP_ASSERT_NOW(a_result_restarts, res_o.valid, pos_d == PosHdr0,
                  "A result did not restart the frame.")
  `LFP_ASSERT_NXT(a_csum_to_end, step_i && pos_q == PosCsum, pos_q == PosEnd0,
                  "Checksum byte not followed by first end mark.")

endmodule

// ===== hdl/lidar_frame_parser.sv =====
// Top level of the range-sensor frame parser with its input and result registers.
//
// Parses a serial byte stream from a range sensor, one received byte per
// input item, looking for 27-byte frames that start with 0xAE 0xA7. A length
// byte of 0x04 yields an acknowledge result (distance 1, tuser 1) at once; a
// length byte of 0x17 starts a measurement frame that must end in 0xBC 0xBE and
// whose 8-bit additive checksum over bytes 2 to 23 must match byte 24. A good
// measurement frame yields the big-endian value of bytes 7 and 8 times ten
// (never below 1), with tuser 0; bad bytes are dropped and the frame restarts.
// The block takes one item per clock cycle while the result register is free or
// being emptied. A result passes from the input register through the parser core
// into the result register once the byte that completes its frame moves on. One
// byte can be accepted while a result waits to be taken.
`include "lidar_frame_parser_defines.svh"

module lidar_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [19:0] distance, [23:20] zero
  output logic        m_axis_tuser_o    // [0] frame_kind
);
  import lfp_pkg::*;

  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             out_valid_q;
  logic [DistW-1:0] out_dist_q;
  logic             out_kind_q;
  logic             advance;
  logic             in_accept;
  lfp_result_t      core_res;

  // The held byte moves on once the result register is free or being emptied.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  lfp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .res_o  (core_res)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= core_res.valid;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && core_res.valid) begin
      out_dist_q <= core_res.distance;
      out_kind_q <= core_res.frame_kind;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, out_dist_q};
  assign m_axis_tuser_o  = out_kind_q;

  `LFP_ASSERT_NOW(a_ack_is_one, m_axis_tvalid_o && m_axis_tuser_o == KindAck,
                  m_axis_tdata_o[19:0] == DistMin, "Acknowledge result is not distance one.")
  `LFP_ASSERT_NOW(a_dist_nonzero, m_axis_tvalid_o, m_axis_tdata_o[19:0] != '0,
                  "Result distance is zero.")
  `LFP_ASSERT_NXT(a_byte_held, in_valid_q && out_valid_q && !m_axis_tready_i,
                  in_valid_q && $stable(in_byte_q), "Held byte lost while output stalled.")

endmodule

// ===== bench/lfp_range_monitor.sv =====
// Monitor that predicts frame parser results from accepted bytes and checks them.
`timescale 1ns / 100ps

module lfp_range_monitor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [23:0] m_axis_tdata_i,   // [19:0] distance, [23:20] zero
  input  logic        m_axis_tuser_i,   // [0] frame_kind
  output int unsigned fault_count_o,
  output int unsigned outstanding_o
);
  import lfp_pkg::*;

  localparam logic [DistW-1:0] DistScale = 20'd10;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic             frame_kind;
  } range_result_t;

  // Shadow copy of the parser's frame state.
  logic [PosW-1:0]  frame_pos;
  logic [ByteW-1:0] run_sum;
  logic [ByteW-1:0] frame_csum;
  logic [ByteW-1:0] frame_hi;
  logic [ByteW-1:0] frame_lo;

  range_result_t pending_ranges[$];

  initial fault_count_o = 0;
  initial outstanding_o = 0;

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fault_count_o++;
  endtask

  // Advances the shadow frame state by one received byte and queues any result.
  task automatic advance_frame(input logic [ByteW-1:0] rx);
    logic [DistW-1:0] range_val;
    case (frame_pos)
      PosHdr0: frame_pos = (rx == Hdr0) ? PosHdr1 : PosHdr0;
      PosHdr1: frame_pos = (rx == Hdr1) ? PosLen : PosHdr0;
      PosLen: begin
        if (rx == LenAck) begin
          frame_pos = PosHdr0;
          pending_ranges.push_back('{distance: DistMin, frame_kind: KindAck});
        end else if (rx != LenMeas) begin
          frame_pos = PosHdr0;
        end else begin
          run_sum   = rx;
          frame_pos = PosFirstSum;
        end
      end
      PosCsum: begin
        frame_csum = rx;
        frame_pos  = PosEnd0;
      end
      PosEnd0: frame_pos = (rx == End0) ? PosEnd1 : PosHdr0;
      PosEnd1: begin
        frame_pos = PosHdr0;
        if (rx == End1 && frame_csum == run_sum) begin
          range_val = {4'b0, frame_hi, frame_lo} * DistScale;
          if (range_val == '0) range_val = DistMin;
          pending_ranges.push_back('{distance: range_val, frame_kind: KindMeas});
        end
      end
      default: begin
        // Payload bytes are summed; positions past the end mark restart the frame.
        if (frame_pos >= PosFirstSum && frame_pos <= PosLastSum) begin
          run_sum = run_sum + rx;
          if (frame_pos == PosHi) frame_hi = rx;
          if (frame_pos == PosLo) frame_lo = rx;
          frame_pos = frame_pos + 1'b1;
        end else begin
          frame_pos = PosHdr0;
        end
      end
    endcase
  endtask

  // Watch both channels at every edge; results lag the bytes that complete their frames.
  always @(posedge clk_i or negedge rst_ni) begin
    range_result_t want;
    if (!rst_ni) begin
      frame_pos  = PosHdr0;
      run_sum    = '0;
      frame_csum = '0;
      frame_hi   = '0;
      frame_lo   = '0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (pending_ranges.size() == 0) begin
          report_mismatch($sformatf("unexpected result distance %0d kind %0b",
                                    m_axis_tdata_i[DistW-1:0], m_axis_tuser_i));
        end else begin
          want = pending_ranges.pop_front();
          if (m_axis_tdata_i[DistW-1:0] != want.distance)
            report_mismatch($sformatf("distance %0d, expected %0d",
                                      m_axis_tdata_i[DistW-1:0], want.distance));
          if (m_axis_tuser_i != want.frame_kind)
            report_mismatch($sformatf("frame kind %0b, expected %0b",
                                      m_axis_tuser_i, want.frame_kind));
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) advance_frame(s_axis_tdata_i);
      outstanding_o = pending_ranges.size();
    end
  end

endmodule

// ===== bench/tb_lidar_frame_parser.sv =====
// Top of the frame parser testbench: clock, reset, byte stimulus and verdict.
`timescale 1ns / 100ps

module tb_lidar_frame_parser;
  import lfp_pkg::*;

  localparam int unsigned ByteBudget    = 1250;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned FrameLen      = 27;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;

  int unsigned fault_count;
  int unsigned outstanding;
  int unsigned idle_cycles = 0;
  int unsigned bytes_sent = 0;
  int unsigned send_calm = 0;
  int unsigned take_calm = 0;

  lidar_frame_parser dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  lfp_range_monitor u_range_monitor (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tuser_i  (m_axis_tuser),
    .fault_count_o   (fault_count),
    .outstanding_o   (outstanding)
  );

  // Clock and a single reset pulse.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Draws a random idle gap, with occasional stretches of no idling.
  function automatic int unsigned draw_gap(ref int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) calm = $urandom_range(20, 80);
    return $urandom_range(0, 8);
  endfunction

  // Offers one byte after a random gap and waits until it is accepted.
  task automatic push_byte(input logic [7:0] rx);
    int unsigned gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rx;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic send_ack_frame();
    push_byte(Hdr0);
    push_byte(Hdr1);
    push_byte(LenAck);
  endtask

  // Builds a measurement frame carrying the given value; it can be damaged at one
  // byte, carry a wrong checksum, or be cut short after keep_bytes bytes.
  task automatic send_meas_frame(input logic [15:0] value, input int corrupt_at,
                                 input bit bad_sum, input int unsigned keep_bytes);
    logic [7:0] frame [FrameLen];
    logic [7:0] sum;
    frame[PosHdr0] = Hdr0;
    frame[PosHdr1] = Hdr1;
    frame[PosLen]  = LenMeas;
    for (int i = PosFirstSum; i <= PosLastSum; i++) frame[i] = 8'($urandom);
    frame[PosHi] = value[15:8];
    frame[PosLo] = value[7:0];
    sum = '0;
    for (int i = PosLen; i <= PosLastSum; i++) sum = sum + frame[i];
    frame[PosCsum] = bad_sum ? (sum ^ 8'($urandom_range(1, 255))) : sum;
    frame[PosEnd0] = End0;
    frame[PosEnd1] = End1;
    if (corrupt_at >= 0) frame[corrupt_at] = frame[corrupt_at] ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < keep_bytes; i++) push_byte(frame[i]);
  endtask

  // Random 16-bit value, now and then at either extreme.
  function automatic logic [15:0] draw_value();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Byte stimulus: directed frames first, then mostly good frames with random content.
  initial begin
    int unsigned pick;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);

    send_ack_frame();
    // A repeated first header byte is dropped, not taken as a new frame start.
    push_byte(Hdr0);
    push_byte(Hdr0);
    push_byte(Hdr1);
    push_byte(LenAck);
    push_byte(8'h00);
    push_byte(8'hFF);
    send_meas_frame(16'hFFFF, -1, 1'b0, FrameLen);
    send_meas_frame(16'h0000, -1, 1'b0, FrameLen);
    send_meas_frame(16'h1234, -1, 1'b1, FrameLen);
    send_meas_frame(16'h00FF, PosLen, 1'b0, FrameLen);
    send_meas_frame(16'hFF00, PosEnd0, 1'b0, FrameLen);
    send_meas_frame(16'h8001, PosEnd1, 1'b0, FrameLen);
    send_ack_frame();

    while (bytes_sent < ByteBudget) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_meas_frame(draw_value(), -1, 1'b0, FrameLen);
      end else if (pick < 68) begin
        send_ack_frame();
      end else if (pick < 80) begin
        send_meas_frame(draw_value(), $urandom_range(0, FrameLen - 1), 1'b0, FrameLen);
      end else if (pick < 85) begin
        send_meas_frame(draw_value(), -1, 1'b1, FrameLen);
      end else if (pick < 92) begin
        send_meas_frame(draw_value(), -1, 1'b0, $urandom_range(1, FrameLen - 1));
      end else begin
        // Line noise, leaning toward header bytes.
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 3))
            0:       push_byte(Hdr0);
            1:       push_byte(Hdr1);
            default: push_byte(8'($urandom));
          endcase
        end
      end
    end
    s_axis_tvalid <= 1'b0;

    while (outstanding != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Result side: stalls a random number of cycles before taking each item.
  initial begin
    int unsigned stall;
    forever begin
      stall = draw_gap(take_calm);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Watchdog on cycles in which neither side moves an item.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
